// ===== src/mm_pkg.sv =====
// shared constants for the montgomery multiplier
`default_nettype none

package mm_pkg;

    localparam int MM_OPERAND_WIDTH = 64;
    localparam int MM_FIELD_W       = 64;
    localparam int MM_COUNT_W       = 7;
    localparam int MM_CFG_INDEX_W   = 1;

    typedef enum logic [MM_CFG_INDEX_W-1:0] {
        CFG_MODULUS   = 1'b0,
        CFG_BIT_COUNT = 1'b1
    } t_cfg_index;

endpackage

`default_nettype wire

// ===== src/montgomery_multiplier.sv =====
// Radix-2 Montgomery multiplier, top level. Returns a*b*2^-n mod p for the
// configured odd modulus p and step count n (bit_count, capped at
// OPERAND_WIDTH). The datapath is one entry stage, one register stage per
// operand bit and one subtraction stage; a new word is taken every cycle,
// but the whole pipeline holds while the output word waits. Only the low
// OPERAND_WIDTH bits of operands and modulus are used. Write the config
// registers only while the pipeline is empty.
`default_nettype none

module montgomery_multiplier import mm_pkg::*; #(
    parameter int OPERAND_WIDTH = MM_OPERAND_WIDTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [MM_CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [MM_FIELD_W-1:0]     i_cfg_data,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // multiplicand_in [63:0], multiplier_in [127:64]
    input  wire logic [2*MM_FIELD_W-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // product_out [63:0]
    output logic [MM_FIELD_W-1:0]          m_axis_tdata
);

    localparam int W  = OPERAND_WIDTH;
    localparam int SW = $clog2(W + 1);

    logic [MM_FIELD_W-1:0] r_modulus;
    logic [MM_COUNT_W-1:0] r_bit_count;
    logic [SW-1:0]         w_steps;
    logic [W-1:0]          w_p;
    logic                  w_en;

    logic [W:0]   w_valid;
    logic [W:0]   w_acc [0:W];
    logic [W-1:0] w_a   [0:W];
    logic [W-1:0] w_b   [0:W];
    logic [W:0]   w_bp  [0:W];

    logic         w_out_valid;
    logic [W-1:0] w_product;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MM_FIELD_W'(3);
            r_bit_count <= MM_COUNT_W'(2);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MODULUS:   r_modulus   <= i_cfg_data;
                CFG_BIT_COUNT: r_bit_count <= i_cfg_data[MM_COUNT_W-1:0];
                default:       r_modulus   <= r_modulus;
            endcase
        end
    end

    assign w_steps = (r_bit_count > MM_COUNT_W'(W)) ? SW'(W) : SW'(r_bit_count);
    assign w_p     = r_modulus[W-1:0];

    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    mm_pre #(
        .W (W)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_a     (s_axis_tdata[W-1:0]),
        .i_b     (s_axis_tdata[MM_FIELD_W+W-1:MM_FIELD_W]),
        .i_p     (w_p),
        .o_valid (w_valid[0]),
        .o_a     (w_a[0]),
        .o_b     (w_b[0]),
        .o_bp    (w_bp[0])
    );

    assign w_acc[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_step
        mm_step #(
            .W     (W),
            .STAGE (g),
            .SW    (SW)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_steps (w_steps),
            .i_p     (w_p),
            .i_valid (w_valid[g]),
            .i_acc   (w_acc[g]),
            .i_a     (w_a[g]),
            .i_b     (w_b[g]),
            .i_bp    (w_bp[g]),
            .o_valid (w_valid[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_a     (w_a[g+1]),
            .o_b     (w_b[g+1]),
            .o_bp    (w_bp[g+1])
        );
    end

    mm_final #(
        .W (W)
    ) u_final (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_p       (w_p),
        .i_valid   (w_valid[W]),
        .i_acc     (w_acc[W]),
        .o_valid   (w_out_valid),
        .o_product (w_product)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = MM_FIELD_W'(w_product);

`ifndef NO_ASSERTIONS
    a_stall_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_valid))
        else $error("pipeline valid bits moved during a stall");

    a_last_step_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[W] && w_en) |=> m_axis_tvalid)
        else $error("word from last step did not reach the output");

    a_entry_follows_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_valid[0])
        else $error("accepted word did not enter the pipeline");
`endif

endmodule

`default_nettype wire

// ===== src/mm_pre.sv =====
// entry stage: registers operands and forms multiplier plus modulus
`default_nettype none

module mm_pre import mm_pkg::*; #(
    parameter int W = MM_OPERAND_WIDTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_p,
    output logic              o_valid,
    output logic [W-1:0]      o_a,
    output logic [W-1:0]      o_b,
    output logic [W:0]        o_bp
);

    logic         r_valid;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic [W:0]   r_bp;
    logic [W:0]   n_bp;

    assign n_bp = {1'b0, i_b} + {1'b0, i_p};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_bp <= n_bp;
        end
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_bp    = r_bp;

endmodule

`default_nettype wire

// ===== src/mm_step.sv =====
// one reduction step: conditional add of multiplier and modulus, then halve
`default_nettype none

module mm_step import mm_pkg::*; #(
    parameter int W     = MM_OPERAND_WIDTH,
    parameter int STAGE = 0,
    parameter int SW    = $clog2(W + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [SW-1:0] i_steps,
    input  wire logic [W-1:0]  i_p,
    input  wire logic          i_valid,
    input  wire logic [W:0]    i_acc,
    input  wire logic [W-1:0]  i_a,
    input  wire logic [W-1:0]  i_b,
    input  wire logic [W:0]    i_bp,
    output logic               o_valid,
    output logic [W:0]         o_acc,
    output logic [W-1:0]       o_a,
    output logic [W-1:0]       o_b,
    output logic [W:0]         o_bp
);

    localparam logic [SW-1:0] IDX = SW'(STAGE);

    logic         r_valid;
    logic [W:0]   r_acc;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic [W:0]   r_bp;

    logic         w_odd;
    logic [W:0]   w_addend;
    logic [W+1:0] w_sum;
    logic [W:0]   n_acc;

    assign w_odd = i_acc[0] ^ (i_a[0] & i_b[0]);

    always_comb begin
        unique case ({i_a[0], w_odd})
            2'b11:   w_addend = i_bp;
            2'b10:   w_addend = {1'b0, i_b};
            2'b01:   w_addend = {1'b0, i_p};
            default: w_addend = '0;
        endcase
    end

    assign w_sum = {1'b0, i_acc} + {1'b0, w_addend};
    // steps past the configured count pass the accumulator through unchanged
    assign n_acc = (IDX < i_steps) ? w_sum[W+1:1] : i_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
            r_a   <= i_a >> 1;
            r_b   <= i_b;
            r_bp  <= i_bp;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_bp    = r_bp;

endmodule

`default_nettype wire

// ===== src/mm_final.sv =====
// output stage: conditional subtraction of the modulus
`default_nettype none

module mm_final import mm_pkg::*; #(
    parameter int W = MM_OPERAND_WIDTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_p,
    input  wire logic         i_valid,
    input  wire logic [W:0]   i_acc,
    output logic              o_valid,
    output logic [W-1:0]      o_product
);

    logic         r_valid;
    logic [W-1:0] r_product;
    logic [W:0]   w_diff;
    logic [W-1:0] n_product;

    assign w_diff    = i_acc - {1'b0, i_p};
    assign n_product = (i_acc >= {1'b0, i_p}) ? w_diff[W-1:0] : i_acc[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_product <= n_product;
        end
    end

    assign o_valid   = r_valid;
    assign o_product = r_product;

endmodule

`default_nettype wire
